[src/extremum_limiting_line_filter_assert.svh]
// assertion macros for the extremum limiting line filter rtl
// no dependencies; included by the top level, which carries the concurrent checks
`ifndef EXTREMUM_LIMITING_LINE_FILTER_ASSERT_SVH
`define EXTREMUM_LIMITING_LINE_FILTER_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define ELF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define ELF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/elf_pkg.sv]
`timescale 1ns / 1ps
// shared widths, types and codes for the extremum limiting line filter
// no dependencies; imported by every module of the block
package elf_pkg;

	localparam int SAMPLE_WIDTH     = 32;
	localparam int WEIGHT_WIDTH     = 16;
	localparam int WEIGHT_FRAC_BITS = 15;
	localparam logic [WEIGHT_WIDTH-1:0] WEIGHT_RESET = 16'd32768;

	// exact neighbour difference, weighted product, amount and adjusted sum
	localparam int DIFF_W = SAMPLE_WIDTH + 1;
	localparam int PROD_W = DIFF_W + WEIGHT_WIDTH + 1;
	localparam int AMT_W  = PROD_W - WEIGHT_FRAC_BITS;
	localparam int SUM_W  = AMT_W + 1;

	// held sample count codes
	localparam logic [1:0] HELD_NONE = 2'd0;
	localparam logic [1:0] HELD_ONE  = 2'd1;
	localparam logic [1:0] HELD_TWO  = 2'd2;

	// result queue
	localparam int Q_DEPTH  = 4;
	localparam int Q_PTR_W  = 2;
	localparam int Q_CNT_W  = 3;
	localparam int PUSH_MAX = 3;
	localparam int PUSH_W   = 2;

	typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
	typedef logic [WEIGHT_WIDTH-1:0] weight_t;

	typedef struct packed {
		sample_t value;
		logic    last;
	} result_t;

	typedef struct packed {
		logic [PUSH_W-1:0]      count;
		result_t [PUSH_MAX-1:0] item;
	} push_t;

	typedef struct packed {
		logic [1:0] held_cnt;
		sample_t    left;
		sample_t    mid;
	} hold_t;

endpackage

[src/elf_core.sv]
`timescale 1ns / 1ps
// limiter datapath: extremum test, weighted amount, saturation, result release
// depends on elf_pkg
module elf_core (
	input  elf_pkg::hold_t   hold,
	input  elf_pkg::sample_t x,
	input  logic             fin,
	input  elf_pkg::weight_t weight,
	output elf_pkg::hold_t   hold_nxt,
	output elf_pkg::push_t   push
);
	import elf_pkg::*;

	function automatic sample_t sat_sample(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] hi;
		logic signed [SUM_W-1:0] lo;
		hi = SUM_W'($signed({1'b0, {(SAMPLE_WIDTH-1){1'b1}}}));
		lo = ~hi;
		if (v > hi) begin
			return sample_t'({1'b0, {(SAMPLE_WIDTH-1){1'b1}}});
		end else if (v < lo) begin
			return sample_t'({1'b1, {(SAMPLE_WIDTH-1){1'b0}}});
		end
		return sample_t'(v[SAMPLE_WIDTH-1:0]);
	endfunction

	logic signed [DIFF_W-1:0] dp, dm, d_big, d_small;
	logic [DIFF_W-1:0]        mag_dp, mag_dm;
	logic                     extremum, plus_big;
	logic signed [WEIGHT_WIDTH:0] w_s;
	logic signed [PROD_W-1:0] prod_big, prod_small;
	logic signed [AMT_W-1:0]  ep, em, e;
	logic [AMT_W-1:0]         mag_ep, mag_em;
	sample_t                  side, side_adj, mid_adj;
	sample_t                  left2, mid2, x2;

	assign dp = DIFF_W'(x) - DIFF_W'(hold.mid);
	assign dm = DIFF_W'(hold.left) - DIFF_W'(hold.mid);
	assign extremum = (dp != '0) && (dm != '0) && (dp[DIFF_W-1] == dm[DIFF_W-1]);
	assign mag_dp = dp[DIFF_W-1] ? DIFF_W'(-dp) : DIFF_W'(dp);
	assign mag_dm = dm[DIFF_W-1] ? DIFF_W'(-dm) : DIFF_W'(dm);
	// equal magnitudes put the big side on the left neighbour
	assign plus_big = mag_dp > mag_dm;
	assign d_big    = plus_big ? dp : dm;
	assign d_small  = plus_big ? dm : dp;

	assign w_s        = $signed({1'b0, weight});
	assign prod_big   = PROD_W'(w_s) * PROD_W'(d_big);
	assign prod_small = PROD_W'(w_s) * PROD_W'(d_small);
	// half of the big difference costs one more bit of shift
	assign ep = AMT_W'(prod_big >>> (WEIGHT_FRAC_BITS + 1));
	assign em = AMT_W'(prod_small >>> WEIGHT_FRAC_BITS);
	assign mag_ep = ep[AMT_W-1] ? AMT_W'(-ep) : AMT_W'(ep);
	assign mag_em = em[AMT_W-1] ? AMT_W'(-em) : AMT_W'(em);
	assign e = (mag_ep < mag_em) ? ep : em;

	assign side     = plus_big ? x : hold.left;
	assign side_adj = sat_sample(SUM_W'(side) - SUM_W'(e));
	assign mid_adj  = sat_sample(SUM_W'(hold.mid) + SUM_W'(e));

	assign left2 = (extremum && !plus_big) ? side_adj : hold.left;
	assign x2    = (extremum && plus_big) ? side_adj : x;
	assign mid2  = extremum ? mid_adj : hold.mid;

	always_comb begin
		hold_nxt   = hold;
		push       = '0;
		unique case (hold.held_cnt)
			HELD_NONE: begin
				if (fin) begin
					push.count   = PUSH_W'(1);
					push.item[0] = '{value: x, last: 1'b1};
				end else begin
					hold_nxt.mid      = x;
					hold_nxt.held_cnt = HELD_ONE;
				end
			end
			HELD_ONE: begin
				if (fin) begin
					push.count        = PUSH_W'(2);
					push.item[0]      = '{value: hold.mid, last: 1'b0};
					push.item[1]      = '{value: x, last: 1'b1};
					hold_nxt.held_cnt = HELD_NONE;
				end else begin
					hold_nxt.left     = hold.mid;
					hold_nxt.mid      = x;
					hold_nxt.held_cnt = HELD_TWO;
				end
			end
			HELD_TWO: begin
				push.item[0] = '{value: left2, last: 1'b0};
				if (fin) begin
					push.count        = PUSH_W'(3);
					push.item[1]      = '{value: mid2, last: 1'b0};
					push.item[2]      = '{value: x2, last: 1'b1};
					hold_nxt.held_cnt = HELD_NONE;
				end else begin
					push.count    = PUSH_W'(1);
					hold_nxt.left = mid2;
					hold_nxt.mid  = x2;
				end
			end
			default: begin
				hold_nxt.held_cnt = HELD_NONE;
			end
		endcase
	end

endmodule

[src/elf_outq.sv]
`timescale 1ns / 1ps
// result queue: takes up to three results per cycle, hands out one per cycle while head_ready is high
// depends on elf_pkg
module elf_outq (
	input  logic             clk,
	input  logic             arst_n,
	input  elf_pkg::push_t   push,
	output logic             room,
	output elf_pkg::result_t head,
	output logic             head_valid,
	input  logic             head_ready
);
	import elf_pkg::*;

	result_t              q_mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [Q_CNT_W-1:0]   occ_q;
	logic                 pop;

	assign head_valid = occ_q != '0;
	assign head       = q_mem_q[rd_ptr_q];
	assign pop        = head_valid && head_ready;
	assign room       = occ_q <= Q_CNT_W'(Q_DEPTH - PUSH_MAX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			occ_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + Q_PTR_W'(push.count);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
			end
			occ_q <= occ_q + Q_CNT_W'(push.count) - Q_CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < PUSH_MAX; k++) begin
			if (k < int'(push.count)) begin
				q_mem_q[wr_ptr_q + Q_PTR_W'(k)] <= push.item[k];
			end
		end
	end

endmodule

[src/extremum_limiting_line_filter.sv]
`timescale 1ns / 1ps
// top level of the extremum limiting line filter: input stage, hold state, weight register
// depends on elf_pkg, elf_core, elf_outq and extremum_limiting_line_filter_assert.svh
//
// the limiter math is one pass from the input register to the queue, which registers the results
// throughput: one sample per cycle while the queue has room
// a last sample releases up to three results that drain one per cycle with m_axis open;
//   the next line waits until the four-entry queue holds at most one result
// reset: weight returns to 32768 (1.0), nothing is held, the queue is empty
`include "extremum_limiting_line_filter_assert.svh"
module extremum_limiting_line_filter (
	input  logic                       clk,
	input  logic                       arst_n,
	// input sample stream
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	input  logic [31:0]                s_axis_tdata,  // [31:0] sample
	input  logic                       s_axis_tlast,  // last sample of the line
	// filtered sample stream
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	output logic [31:0]                m_axis_tdata,  // [31:0] filtered
	output logic                       m_axis_tlast,  // last_out
	// weight register write
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [elf_pkg::WEIGHT_WIDTH-1:0] cfg_data
);
	import elf_pkg::*;

	// filter strength, unsigned q1.15
	weight_t weight_q;

	// input stage
	logic    valid_s1_q;
	sample_t sample_s1;
	logic    last_s1;

	// held window: count is control, samples are payload
	logic [1:0] held_cnt_q;
	sample_t    left_q, mid_q;

	hold_t   hold, hold_nxt;
	push_t   push_raw, push;
	result_t head;
	logic    room, adv;

	// the staged item goes through once the queue can take a full flush
	assign adv           = valid_s1_q && room;
	assign s_axis_tready = !valid_s1_q || adv;
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q <= WEIGHT_RESET;
		end else if (cfg_valid) begin
			weight_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1_q <= 1'b0;
			held_cnt_q <= HELD_NONE;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				valid_s1_q <= 1'b1;
			end else if (adv) begin
				valid_s1_q <= 1'b0;
			end
			if (adv) begin
				held_cnt_q <= hold_nxt.held_cnt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			sample_s1 <= sample_t'(s_axis_tdata);
			last_s1   <= s_axis_tlast;
		end
		if (adv) begin
			left_q <= hold_nxt.left;
			mid_q  <= hold_nxt.mid;
		end
	end

	assign hold = '{held_cnt: held_cnt_q, left: left_q, mid: mid_q};

	elf_core u_core (
		.hold     (hold),
		.x        (sample_s1),
		.fin      (last_s1),
		.weight   (weight_q),
		.hold_nxt (hold_nxt),
		.push     (push_raw)
	);

	// nothing enters the queue unless the staged item really moves on
	always_comb begin
		push = push_raw;
		if (!adv) begin
			push.count = '0;
		end
	end

	elf_outq u_outq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.room       (room),
		.head       (head),
		.head_valid (m_axis_tvalid),
		.head_ready (m_axis_tready)
	);

	assign m_axis_tdata = head.value;
	assign m_axis_tlast = head.last;

	// a stalled staged item keeps its sample
	`ELF_ASSERT_NEXT(a_stall_holds, clk, arst_n, valid_s1_q && !adv, valid_s1_q && $stable(sample_s1), "staged item lost while stalled")
	// only a line end releases three results
	`ELF_ASSERT_NOW(a_flush_on_last, clk, arst_n, push.count == PUSH_W'(PUSH_MAX), last_s1, "three results without last")
	// a line end leaves nothing held
	`ELF_ASSERT_NEXT(a_flush_empties, clk, arst_n, adv && last_s1, held_cnt_q == HELD_NONE, "samples held after line end")
	// a released result is offered on the next cycle
	`ELF_ASSERT_NEXT(a_push_shows, clk, arst_n, push.count != '0, m_axis_tvalid, "released result not offered")

endmodule
